// ===== sv/javs_pkg.sv =====
// Package for the joint acceleration velocity scale block.
// Holds field widths, register indexes, fixed-point constants and the control state type.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package javs_pkg;

  localparam int VEL_W       = 32;
  localparam int MAG_W       = 32;
  localparam int ACC_W       = 31;
  localparam int TS_W        = 16;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_W       = 31;
  localparam int FAC_W       = 17;
  localparam int PROD_W      = ACC_W + TS_W;
  localparam int NUM_W       = 48;
  localparam int LIMIT_SLOTS = 7;
  localparam int MUL_STEPS   = TS_W;
  localparam int DIV_STEPS   = NUM_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [FAC_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [TS_W-1:0]  TS_RESET = 16'd66;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_FIRST = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_LAST  = 4'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== sv/javs_mul.sv =====
// Bit-serial multiplier: acceleration limit times time step, one step bit per cycle.
// Depends on javs_pkg for widths and step count.
`timescale 1ns / 1ps

module javs_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [javs_pkg::ACC_W-1:0]  a_i,
  input  logic [javs_pkg::TS_W-1:0]   b_i,
  output logic                       done_o,
  output logic [javs_pkg::PROD_W-1:0] prod_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [javs_pkg::MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [javs_pkg::ACC_W-1:0]     a_q, a_d;
  logic [javs_pkg::TS_W-1:0]      b_q, b_d;
  logic [javs_pkg::PROD_W-1:0]    prod_q, prod_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      prod_d = '0;
    end else if (busy_q) begin
      prod_d = {prod_q[javs_pkg::PROD_W-2:0], 1'b0}
             + (b_q[javs_pkg::TS_W-1] ? javs_pkg::PROD_W'(a_q) : '0);
      b_d    = {b_q[javs_pkg::TS_W-2:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == javs_pkg::MUL_CNT_W'(javs_pkg::MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== sv/javs_div.sv =====
// Restoring bit-serial divider giving a Q1.16 quotient saturated at 1.0.
// One dividend bit is shifted in per cycle. Depends on javs_pkg.
`timescale 1ns / 1ps

module javs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [javs_pkg::NUM_W-1:0]  dividend_i,
  input  logic [javs_pkg::MAG_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [javs_pkg::FAC_W-1:0]  quotient_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [javs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [javs_pkg::NUM_W-1:0]     num_q, num_d;
  logic [javs_pkg::MAG_W-1:0]     div_q, div_d;
  logic [javs_pkg::MAG_W-2:0]     rem_q, rem_d;
  logic [javs_pkg::FAC_W-1:0]     quo_q, quo_d;
  logic                           sat_q, sat_d;
  logic [javs_pkg::MAG_W-1:0]     trial;
  logic [javs_pkg::MAG_W-1:0]     diff;
  logic                           fits;

  assign trial = {rem_q, num_q[javs_pkg::NUM_W-1]};
  assign fits  = trial >= div_q;
  assign diff  = trial - div_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    sat_d  = sat_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      rem_d = fits ? diff[javs_pkg::MAG_W-2:0] : trial[javs_pkg::MAG_W-2:0];
      num_d = {num_q[javs_pkg::NUM_W-2:0], 1'b0};
      sat_d = sat_q | quo_q[javs_pkg::FAC_W-1];
      quo_d = {quo_q[javs_pkg::FAC_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == javs_pkg::DIV_CNT_W'(javs_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign done_o     = done_q;
  assign quotient_o = (sat_q || (quo_q[javs_pkg::FAC_W-1] && (|quo_q[javs_pkg::FAC_W-2:0])))
                    ? javs_pkg::ONE_Q16 : quo_q;

endmodule

// ===== sv/joint_accel_velocity_scale_unit.sv =====
// Top level of the joint acceleration velocity scale block; uses javs_mul, javs_div, javs_pkg.
// A joint with nonzero wanted velocity passes through the serial multiplier, the serial
// divider and the done state; a skipped joint goes straight to the done state. On the last
// joint the factor enters the output register at the edge that ends the joint.
// One joint at a time: no new joint is taken until the last one has left the done state.
// Asynchronous active-low reset restores state, config, out_valid and the minimum of 1.0.
`timescale 1ns / 1ps

module joint_accel_velocity_scale_unit #(
  parameter int JOINT_COUNT = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [javs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [javs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [javs_pkg::IDX_W-1:0]     joint_index_i,
  input  logic signed [javs_pkg::VEL_W-1:0] wanted_velocity_i,
  input  logic signed [javs_pkg::VEL_W-1:0] previous_velocity_i,
  input  logic                          last_joint_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [javs_pkg::FAC_W-1:0]     scale_factor_o
);

  javs_pkg::state_e state_q, state_d;

  logic [javs_pkg::TS_W-1:0]  time_step_q;
  logic [javs_pkg::ACC_W-1:0] accel_q [javs_pkg::LIMIT_SLOTS];
  logic [javs_pkg::CFG_IDX_W-1:0] cfg_slot;

  logic [javs_pkg::FAC_W-1:0] min_q;
  logic [javs_pkg::MAG_W-1:0] pmag_q;
  logic [javs_pkg::MAG_W-1:0] wmag_q;
  logic                       last_q;
  logic                       skip_q;
  logic                       out_valid_q;
  logic [javs_pkg::FAC_W-1:0] out_q;

  logic [javs_pkg::MAG_W-1:0] wmag, pmag;
  logic [javs_pkg::ACC_W-1:0] accel_sel;
  logic                       in_accept;
  logic                       out_free;
  logic                       mul_start, mul_done;
  logic                       div_start, div_done;
  logic                       commit, load_out;
  logic [javs_pkg::PROD_W-1:0] prod;
  logic [javs_pkg::NUM_W-1:0]  dividend;
  logic [javs_pkg::FAC_W-1:0]  ratio;
  logic [javs_pkg::FAC_W-1:0]  new_min;

  assign wmag = wanted_velocity_i[javs_pkg::VEL_W-1]
              ? (~wanted_velocity_i + 1'b1) : wanted_velocity_i;
  assign pmag = previous_velocity_i[javs_pkg::VEL_W-1]
              ? (~previous_velocity_i + 1'b1) : previous_velocity_i;
  assign accel_sel = (joint_index_i < javs_pkg::IDX_W'(JOINT_COUNT))
                   ? accel_q[joint_index_i] : '0;
  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign cfg_slot  = cfg_index_i - javs_pkg::CFG_IDX_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      javs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (wmag == '0) ? javs_pkg::ST_DONE : javs_pkg::ST_MUL;
        end
      end
      javs_pkg::ST_MUL: begin
        if (mul_done) state_d = javs_pkg::ST_DIV;
      end
      javs_pkg::ST_DIV: begin
        if (div_done) state_d = javs_pkg::ST_DONE;
      end
      javs_pkg::ST_DONE: begin
        if (!last_q || out_free) state_d = javs_pkg::ST_IDLE;
      end
      default: state_d = javs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state_q)
      javs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        mul_start  = in_valid_i && (wmag != '0);
      end
      javs_pkg::ST_MUL:  div_start = mul_done;
      javs_pkg::ST_DIV:  ;
      javs_pkg::ST_DONE: commit = !last_q || out_free;
      default: ;
    endcase
  end

  assign load_out = commit && last_q;
  assign dividend = {pmag_q, javs_pkg::TS_W'(0)} + javs_pkg::NUM_W'(prod);
  assign new_min  = (!skip_q && (ratio < min_q)) ? ratio : min_q;

  javs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (accel_sel),
    .b_i     (time_step_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  javs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (wmag_q),
    .done_o     (div_done),
    .quotient_o (ratio)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= javs_pkg::ST_IDLE;
      time_step_q <= javs_pkg::TS_RESET;
      for (int k = 0; k < javs_pkg::LIMIT_SLOTS; k++) begin
        accel_q[k] <= '0;
      end
      min_q       <= javs_pkg::ONE_Q16;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == javs_pkg::REG_TIME_STEP) begin
          time_step_q <= cfg_data_i[javs_pkg::TS_W-1:0];
        end else if (cfg_index_i inside {[javs_pkg::REG_ACC_FIRST:javs_pkg::REG_ACC_LAST]}) begin
          accel_q[cfg_slot[javs_pkg::IDX_W-1:0]] <= cfg_data_i;
        end
      end
      if (commit) begin
        min_q <= last_q ? javs_pkg::ONE_Q16 : new_min;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pmag_q <= pmag;
      wmag_q <= wmag;
      last_q <= last_joint_i;
      skip_q <= (wmag == '0);
    end
    if (load_out) begin
      out_q <= new_min;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scale_factor_o = out_q;

endmodule

// ===== sv/javs_checker.sv =====
// Port-level checker for joint_accel_velocity_scale_unit, attached by the bind below.
// Depends on javs_pkg and on the top level's ports only.
`timescale 1ns / 1ps

module javs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic signed [javs_pkg::VEL_W-1:0] wanted_velocity_i,
  input logic                          last_joint_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [javs_pkg::FAC_W-1:0]     scale_factor_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(scale_factor_o))
    else $error("Stalled output transaction changed.");

  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scale_factor_o <= javs_pkg::ONE_Q16)
    else $error("Scale factor exceeds 1.0.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted while a joint is still in progress.");

  a_skip_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (wanted_velocity_i == '0) && !last_joint_i
    |=> ##1 in_ready_o)
    else $error("Skipped joint did not release the input promptly.");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("Result issued while the block is still busy.");

endmodule

bind joint_accel_velocity_scale_unit javs_checker u_javs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .wanted_velocity_i (wanted_velocity_i),
  .last_joint_i      (last_joint_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .scale_factor_o    (scale_factor_o)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for joint_accel_velocity_scale_unit: directed and random joint
// transactions with an in-bench predictor of the scale factor. Depends on javs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int JOINT_COUNT   = 7;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 400;

  localparam int LIMITS_LOW    = 0;
  localparam int LIMITS_HIGH   = 1;
  localparam int LIMITS_RANDOM = 2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [javs_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [javs_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [javs_pkg::IDX_W-1:0] joint_index_i = '0;
  logic signed [javs_pkg::VEL_W-1:0] wanted_velocity_i = '0;
  logic signed [javs_pkg::VEL_W-1:0] previous_velocity_i = '0;
  logic last_joint_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [javs_pkg::FAC_W-1:0] scale_factor_o;

  logic [javs_pkg::TS_W-1:0] step_model;
  logic [javs_pkg::ACC_W-1:0] accel_model [JOINT_COUNT];
  logic [javs_pkg::FAC_W-1:0] minimum_model;
  logic [javs_pkg::FAC_W-1:0] expected_factors [$];

  int errors = 0;
  int tx_odds = 4;
  int rx_odds = 4;
  int hold_request = 0;
  int hold_left = 0;
  int rx_gap = 0;
  int stall_cycles = 0;

  joint_accel_velocity_scale_unit #(
    .JOINT_COUNT(JOINT_COUNT)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .joint_index_i      (joint_index_i),
    .wanted_velocity_i  (wanted_velocity_i),
    .previous_velocity_i(previous_velocity_i),
    .last_joint_i       (last_joint_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .scale_factor_o     (scale_factor_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] magnitude(input logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - 64'(v)) : 64'(v);
  endfunction

  task automatic predict_factor(input logic [javs_pkg::IDX_W-1:0] idx, input logic [31:0] want,
                                input logic [31:0] prev, input logic last);
    logic [63:0] want_mag;
    logic [63:0] accel;
    logic [63:0] ratio;
    want_mag = magnitude(want);
    if (want_mag != 0) begin
      accel = 64'd0;
      if (idx < JOINT_COUNT) begin
        accel = 64'(accel_model[idx]);
      end
      ratio = ((magnitude(prev) << 16) + accel * 64'(step_model)) / want_mag;
      if (ratio > 64'(javs_pkg::ONE_Q16)) begin
        ratio = 64'(javs_pkg::ONE_Q16);
      end
      if (ratio < 64'(minimum_model)) begin
        minimum_model = ratio[javs_pkg::FAC_W-1:0];
      end
    end
    if (last) begin
      expected_factors.push_back(minimum_model);
      minimum_model = javs_pkg::ONE_Q16;
    end
  endtask

  task automatic write_reg(input logic [javs_pkg::CFG_IDX_W-1:0] index,
                           input logic [javs_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = data;
    @(posedge clk_i);
    if (index == javs_pkg::REG_TIME_STEP) begin
      step_model = data[javs_pkg::TS_W-1:0];
    end else if (index <= javs_pkg::REG_ACC_LAST) begin
      accel_model[index - javs_pkg::REG_ACC_FIRST] = data[javs_pkg::ACC_W-1:0];
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_joint(input logic [javs_pkg::IDX_W-1:0] idx, input logic [31:0] want,
                            input logic [31:0] prev, input logic last);
    int gap;
    gap = 0;
    if (tx_odds > 0 && $urandom_range(0, tx_odds) == 0) begin
      gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    joint_index_i = idx;
    wanted_velocity_i = want;
    previous_velocity_i = prev;
    last_joint_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_factor(idx, want, prev, last);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_factors.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_speed();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        v = '0;
      end
      1: begin
        v = $urandom;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] near_speed(input logic [31:0] want);
    logic [31:0] v;
    v = 32'(magnitude(want)) >> $urandom_range(0, 4);
    v = v - ($urandom & 32'h0000_0FFF);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic load_limits(input int style);
    logic [javs_pkg::TS_W-1:0] step;
    logic [javs_pkg::ACC_W-1:0] accel;
    case (style)
      LIMITS_LOW: step = '0;
      LIMITS_HIGH: step = '1;
      default: begin
        case ($urandom_range(0, 2))
          0: step = 16'($urandom_range(1, 200));
          1: step = 16'($urandom);
          default: step = 16'($urandom_range(20, 2000));
        endcase
      end
    endcase
    write_reg(javs_pkg::REG_TIME_STEP, {15'($urandom), step});
    for (int j = 0; j < JOINT_COUNT; j++) begin
      case (style)
        LIMITS_LOW: accel = '0;
        LIMITS_HIGH: accel = '1;
        default: begin
          case ($urandom_range(0, 4))
            0: accel = '0;
            1: accel = '1;
            2: accel = 31'($urandom);
            default: accel = 31'($urandom >> $urandom_range(8, 28));
          endcase
        end
      endcase
      write_reg(javs_pkg::CFG_IDX_W'(javs_pkg::REG_ACC_FIRST + j), accel);
    end
    write_reg(javs_pkg::CFG_IDX_W'(javs_pkg::REG_ACC_LAST + $urandom_range(1, 8)),
              31'($urandom));
  endtask

  task automatic run_random_periods(input int item_budget);
    int sent;
    int span;
    logic [javs_pkg::IDX_W-1:0] idx;
    logic [31:0] want;
    logic [31:0] prev;
    logic last;
    sent = 0;
    last = 1'b1;
    while (sent < item_budget) begin
      span = $urandom_range(1, JOINT_COUNT);
      for (int k = 0; k < span; k++) begin
        idx = javs_pkg::IDX_W'(k);
        last = (k == span - 1);
        if ($urandom_range(0, 9) == 0) idx = javs_pkg::IDX_W'($urandom_range(0, 7));
        if ($urandom_range(0, 19) == 0) last = ~last;
        want = random_speed();
        prev = ($urandom_range(0, 2) == 0) ? random_speed() : near_speed(want);
        send_joint(idx, want, prev, last);
        sent++;
      end
    end
    if (!last) begin
      send_joint(javs_pkg::IDX_W'(JOINT_COUNT - 1), random_speed(), random_speed(), 1'b1);
    end
    release_input();
  endtask

  task automatic test_reset_defaults();
    send_joint(3'd0, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_joint(3'd0, 32'h0000_0001, 32'h0000_0000, 1'b1);
    send_joint(3'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_joint(3'd2, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    send_joint(3'd3, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_joint(3'd4, 32'hFFFE_0000, 32'h0001_0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(javs_pkg::REG_TIME_STEP, 31'h7FFF_0000);
    write_reg(javs_pkg::REG_ACC_FIRST, 31'h7FFF_FFFF);
    send_joint(3'd0, 32'h0001_0000, 32'h0000_0000, 1'b1);
    wait_drained();
    write_reg(javs_pkg::REG_TIME_STEP, 31'h0001_FFFF);
    for (int j = 0; j < JOINT_COUNT; j++) begin
      write_reg(javs_pkg::CFG_IDX_W'(javs_pkg::REG_ACC_FIRST + j), 31'h7FFF_FFFF);
    end
    write_reg(javs_pkg::CFG_IDX_W'(javs_pkg::REG_ACC_LAST + 1), 31'h0000_0000);
    write_reg('1, 31'h0000_0000);
    send_joint(3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_joint(3'd6, 32'h8000_0000, 32'h0000_0000, 1'b1);
    send_joint(javs_pkg::IDX_W'(JOINT_COUNT), 32'h0001_0000, 32'h0000_0000, 1'b1);
    wait_drained();
    write_reg(javs_pkg::CFG_IDX_W'(javs_pkg::REG_ACC_FIRST + 3), 31'h0000_0000);
    send_joint(3'd3, 32'h0010_0000, 32'hFFF8_0000, 1'b1);
    for (int j = 0; j < JOINT_COUNT; j++) begin
      send_joint(javs_pkg::IDX_W'(j), 32'h8000_0000 >> j, 32'(j) << 12, j == JOINT_COUNT - 1);
    end
    wait_drained();
  endtask

  task automatic test_input_stall();
    load_limits(LIMITS_RANDOM);
    tx_odds = 0;
    hold_request = LONG_HOLD;
    for (int k = 0; k < 30; k++) begin
      send_joint(javs_pkg::IDX_W'(k % 2), random_speed(), random_speed(), (k % 2) == 1);
    end
    wait_drained();
    tx_odds = 4;
  endtask

  task automatic test_sender_pause();
    run_random_periods(10);
    wait_drained();
    run_random_periods(10);
    wait_drained();
  endtask

  task automatic test_random_limits();
    int styles [4];
    int odds [4];
    styles = '{LIMITS_RANDOM, LIMITS_HIGH, LIMITS_RANDOM, LIMITS_LOW};
    odds = '{3, 8, 0, 5};
    for (int p = 0; p < 4; p++) begin
      load_limits(styles[p]);
      tx_odds = odds[p];
      rx_odds = odds[(p + 1) % 4];
      run_random_periods(p == 3 ? 60 : 220);
      wait_drained();
    end
  endtask

  task automatic test_steady_stream();
    tx_odds = 0;
    rx_odds = 0;
    load_limits(LIMITS_RANDOM);
    run_random_periods(70);
  endtask

  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else if (rx_gap > 0) begin
      out_ready_i = 1'b0;
      rx_gap--;
    end else if (rx_odds > 0 && $urandom_range(0, rx_odds) == 0) begin
      out_ready_i = 1'b0;
      rx_gap = $urandom_range(1, 8) - 1;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_factors.size() == 0) begin
        $display("%0t: scale_factor %0d arrived with no transaction pending", $realtime,
                 scale_factor_o);
        errors++;
      end else begin
        if (scale_factor_o !== expected_factors[0]) begin
          $display("%0t: scale_factor expected %0d actual %0d", $realtime,
                   expected_factors[0], scale_factor_o);
          errors++;
        end
        expected_factors.delete(0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("joint_accel_velocity_scale_unit verification failed");
      $finish;
    end
  end

  initial begin
    step_model = javs_pkg::TS_RESET;
    for (int j = 0; j < JOINT_COUNT; j++) accel_model[j] = '0;
    minimum_model = javs_pkg::ONE_Q16;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_input_stall();
    test_sender_pause();
    test_random_limits();
    test_steady_stream();
    release_input();
    while (expected_factors.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("joint_accel_velocity_scale_unit verification clean");
    end else begin
      $display("joint_accel_velocity_scale_unit verification failed");
    end
    $finish;
  end

endmodule
